[rtl/mrhl_pkg.sv]
// Shared constants, register codes and controller/datapath interface types
// for the mean-reversion half-life block. No dependencies.
package mrhl_pkg;

  // Default sizing
  localparam int DEF_MAX_WINDOW  = 1024;
  localparam int DEF_MAX_HORIZON = 64;
  localparam int DEF_PRICE_BITS  = 31;

  // Register file
  localparam int CFG_ADDR_BITS = 3;
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_HORIZON       = 1'b1;
  localparam logic [9:0] WINDOW_LENGTH_RESET = 10'd50;
  localparam logic [6:0] HORIZON_RESET       = 7'd10;

  localparam int SEEN_BITS = 11;
  localparam int RESULT_BITS = 7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;      // take the new close, add it to the window sum
    logic sum_read;   // read one ring entry for the window update
    logic sum_acc;    // fold that entry into the window sum
    logic mul_dev;    // form n * c
    logic abs_dev;    // form the deviation of the new bar
    logic age_read;   // read one pending bar
    logic age_mul;    // form count * c for it
    logic age_cmp;    // test for reversion and write back
    logic emit_read;  // read the bar that leaves the horizon
    logic emit_load;  // load its half life into the output register
    logic store;      // file the new bar and advance pointers
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic sum_done;
    logic age_done;
    logic emit_needed;
    logic out_free;
  } status_t;

endpackage

[rtl/mrhl_ctrl.sv]
// Sequencing state machine for the half-life block.
// Depends on mrhl_pkg for the command and status structs.
module mrhl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              price_valid,
  output logic              price_stall,
  input  mrhl_pkg::status_t status,
  output mrhl_pkg::cmd_t    cmd
);
  import mrhl_pkg::*;

  typedef enum logic [3:0] {
    IDLE, SUM_CHK, SUM_ACC, MUL_DEV, ABS_DEV,
    AGE_CHK, AGE_MUL, AGE_CMP, EMIT_RD, EMIT_WAIT, STORE
  } state_t;

  state_t state;

  assign price_stall = (state != IDLE);

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE:      if (price_valid) state <= SUM_CHK;
        SUM_CHK:   state <= status.sum_done ? MUL_DEV : SUM_ACC;
        SUM_ACC:   state <= SUM_CHK;
        MUL_DEV:   state <= ABS_DEV;
        ABS_DEV:   state <= AGE_CHK;
        AGE_CHK:   state <= status.age_done ? EMIT_RD : AGE_MUL;
        AGE_MUL:   state <= AGE_CMP;
        AGE_CMP:   state <= AGE_CHK;
        EMIT_RD:   state <= status.emit_needed ? EMIT_WAIT : STORE;
        EMIT_WAIT: if (status.out_free) state <= STORE;
        STORE:     state <= IDLE;
        default:   state <= IDLE;
      endcase
    end
  end

  // Decode commands
  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE:      cmd.start     = price_valid;
      SUM_CHK:   cmd.sum_read  = !status.sum_done;
      SUM_ACC:   cmd.sum_acc   = 1'b1;
      MUL_DEV:   cmd.mul_dev   = 1'b1;
      ABS_DEV:   cmd.abs_dev   = 1'b1;
      AGE_CHK:   cmd.age_read  = !status.age_done;
      AGE_MUL:   cmd.age_mul   = 1'b1;
      AGE_CMP:   cmd.age_cmp   = 1'b1;
      EMIT_RD:   cmd.emit_read = status.emit_needed;
      EMIT_WAIT: cmd.emit_load = status.out_free;
      STORE:     cmd.store     = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

[rtl/mrhl_dp.sv]
// Datapath: price ring, pending-bar memory, window sum, shared multiplier
// and output register. Depends on mrhl_pkg; driven by mrhl_ctrl commands.
module mrhl_dp #(
  parameter int MAX_WINDOW  = mrhl_pkg::DEF_MAX_WINDOW,
  parameter int MAX_HORIZON = mrhl_pkg::DEF_MAX_HORIZON,
  parameter int PRICE_BITS  = mrhl_pkg::DEF_PRICE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [PRICE_BITS-1:0]  close_price,
  input  logic [9:0]             window_length,
  input  logic [6:0]             horizon,
  input  mrhl_pkg::cmd_t         cmd,
  output mrhl_pkg::status_t      status,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [6:0]             half_life
);
  import mrhl_pkg::*;

  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int SW  = PRICE_BITS + CW;
  localparam int RAW = $clog2(MAX_WINDOW);
  localparam int PAW = (MAX_HORIZON > 1) ? $clog2(MAX_HORIZON) : 1;
  localparam int HW  = $clog2(MAX_HORIZON + 1);
  localparam int EW  = SW + CW + SW + HW;

  // Memories
  logic [PRICE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [EW-1:0]         pend_mem [MAX_HORIZON];

  logic [PRICE_BITS-1:0] cur_c;
  logic [RAW-1:0]        ring_pos;
  logic [PAW-1:0]        pend_pos;
  logic [SEEN_BITS-1:0]  bars_seen;
  logic [SW-1:0]         window_sum;
  logic [CW-1:0]         prev_n;
  logic [CW-1:0]         cur_n;
  logic [HW-1:0]         cur_h;
  logic [CW-1:0]         sum_idx;
  logic                  sum_sub;
  logic [HW:0]           age;
  logic [SW-1:0]         prod;
  logic [SW-1:0]         dev;
  logic [PRICE_BITS-1:0] ring_rdata;
  logic [EW-1:0]         pend_rdata;

  logic [CW-1:0]  n_calc;
  logic [HW-1:0]  h_calc;
  logic [CW-1:0]  k_sel;
  logic [RAW-1:0] ring_raddr;
  logic [PAW-1:0] pend_addr;
  logic [HW:0]    pend_age;
  logic [SW-1:0]  e_sum;
  logic [CW-1:0]  e_cnt;
  logic [SW-1:0]  e_dev;
  logic [HW-1:0]  e_found;
  logic [SW-1:0]  x_dev;
  logic           hit;
  logic [HW+6:0]  found_ext;

  // Clamp configuration and form the term count
  always_comb begin
    int w, t, h, n;
    w = int'(window_length);
    if (w > MAX_WINDOW - 1) w = MAX_WINDOW - 1;
    t = int'(bars_seen);
    n = ((t < w) ? t : w) + 1;
    n_calc = CW'(n);
    h = int'(horizon);
    if (h < 1) h = 1;
    if (h > MAX_HORIZON) h = MAX_HORIZON;
    h_calc = HW'(h);
  end

  // Ring address of the next window step
  always_comb begin
    int idx;
    k_sel = (sum_idx > cur_n - 1'b1) ? sum_idx : sum_idx + 1'b1;
    idx = int'(ring_pos) + MAX_WINDOW - int'(k_sel);
    if (idx >= MAX_WINDOW) idx = idx - MAX_WINDOW;
    ring_raddr = RAW'(idx);
  end

  // Pending slot of the bar at the chosen age
  always_comb begin
    int idx;
    pend_age = cmd.emit_read ? (HW + 1)'(cur_h) : age;
    idx = int'(pend_pos) + MAX_HORIZON - int'(pend_age);
    if (idx >= MAX_HORIZON) idx = idx - MAX_HORIZON;
    pend_addr = PAW'(idx);
  end

  assign {e_sum, e_cnt, e_dev, e_found} = pend_rdata;
  assign x_dev = (prod >= e_sum) ? prod - e_sum : e_sum - prod;
  assign hit = (e_found == '0) && (e_dev != '0) && ({1'b0, x_dev, 1'b0} <= {2'b0, e_dev});
  assign found_ext = {7'b0, e_found};

  assign status.sum_done    = (sum_idx == cur_n - 1'b1);
  assign status.age_done    = (int'(age) > int'(cur_h)) || (int'(bars_seen) < int'(age));
  assign status.emit_needed = (int'(bars_seen) >= int'(cur_h));
  assign status.out_free    = !result_valid || !result_stall;

  // Ring memory port; the new close lands only after the oldest entry was read
  always_ff @(posedge clk) begin
    if (cmd.store) ring_mem[ring_pos] <= cur_c;
    if (cmd.sum_read) ring_rdata <= ring_mem[ring_raddr];
  end

  // Pending-bar memory port
  always_ff @(posedge clk) begin
    if (cmd.age_cmp && hit) begin
      pend_mem[pend_addr] <= {e_sum, e_cnt, e_dev, age[HW-1:0]};
    end else if (cmd.store) begin
      pend_mem[pend_pos] <= {window_sum, cur_n, dev, {HW{1'b0}}};
    end
    if (cmd.age_read || cmd.emit_read) pend_rdata <= pend_mem[pend_addr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_c   <= close_price;
      cur_n   <= n_calc;
      cur_h   <= h_calc;
      sum_idx <= prev_n;
    end
    if (cmd.sum_read) sum_sub <= (sum_idx > cur_n - 1'b1);
    if (cmd.sum_acc) sum_idx <= sum_sub ? sum_idx - 1'b1 : sum_idx + 1'b1;
    if (cmd.mul_dev) prod <= SW'(cur_n * cur_c);
    if (cmd.age_mul) prod <= SW'(e_cnt * cur_c);
    if (cmd.abs_dev) dev <= (prod >= window_sum) ? prod - window_sum : window_sum - prod;
  end

  // Control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos     <= '0;
      pend_pos     <= '0;
      bars_seen    <= '0;
      window_sum   <= '0;
      prev_n       <= '0;
      age          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.start) window_sum <= window_sum + SW'(close_price);
      if (cmd.sum_acc) begin
        window_sum <= sum_sub ? window_sum - SW'(ring_rdata)
                              : window_sum + SW'(ring_rdata);
      end
      if (cmd.abs_dev) age <= (HW + 1)'(1);
      if (cmd.age_cmp) age <= age + 1'b1;
      if (cmd.store) begin
        prev_n   <= cur_n;
        ring_pos <= (int'(ring_pos) == MAX_WINDOW - 1) ? '0 : ring_pos + 1'b1;
        pend_pos <= (int'(pend_pos) == MAX_HORIZON - 1) ? '0 : pend_pos + 1'b1;
        if (bars_seen != '1) bars_seen <= bars_seen + 1'b1;
      end
      // Hold the result until its transfer
      if (cmd.emit_load) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) half_life <= found_ext[6:0];
  end

endmodule

[rtl/mean_reversion_half_life_unit.sv]
// Mean-reversion half-life unit. Per item the block folds D ring entries into
// the window sum (0 or 1 in steady state, more after a window change) and checks
// A ages (up to horizon), paced by the single ring read port and the shared
// multiplier; it takes no new close until the item is filed, and waits longer
// while an earlier result is stalled. Synchronous reset restores defaults.
module mean_reversion_half_life_unit #(
  parameter int MAX_WINDOW  = mrhl_pkg::DEF_MAX_WINDOW,
  parameter int MAX_HORIZON = mrhl_pkg::DEF_MAX_HORIZON,
  parameter int PRICE_BITS  = mrhl_pkg::DEF_PRICE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mrhl_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic [PRICE_BITS-1:0]              close_price,
  input  logic                               price_valid,
  output logic                               price_stall,
  output logic [6:0]                         half_life,
  output logic                               result_valid,
  input  logic                               result_stall
);
  import mrhl_pkg::*;

  logic [9:0] window_length;
  logic [6:0] horizon;
  cmd_t       cmd;
  status_t    status;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
      horizon       <= HORIZON_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WINDOW_LENGTH: window_length <= pwdata[9:0];
        REG_HORIZON:       horizon       <= pwdata[6:0];
        default:           ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_LENGTH: prdata = {22'b0, window_length};
      REG_HORIZON:       prdata = {25'b0, horizon};
      default:           prdata = '0;
    endcase
  end

  mrhl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .price_valid (price_valid),
    .price_stall (price_stall),
    .status      (status),
    .cmd         (cmd)
  );

  mrhl_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .MAX_HORIZON (MAX_HORIZON),
    .PRICE_BITS  (PRICE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .close_price   (close_price),
    .window_length (window_length),
    .horizon       (horizon),
    .cmd           (cmd),
    .status        (status),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .half_life     (half_life)
  );

`ifndef NO_ASSERTIONS
  // Filing a bar ends the item
  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.store |=> !price_stall)
    else $error("controller did not return to idle after store");

  // At most one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("overlapping datapath commands");

  // Never overwrite a result that still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (!result_valid || !result_stall))
    else $error("result overwritten before transfer");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for mean_reversion_half_life_unit: drives closes
// and APB register writes, predicts half lives in-line. Depends on mrhl_pkg.
module tb_top;
  import mrhl_pkg::*;

  localparam int WIN_DEPTH = 1024;
  localparam int HOR_DEPTH = 64;
  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic [30:0] close_price = '0;
  logic price_valid = 1'b0;
  logic price_stall;
  logic [6:0] half_life;
  logic result_valid;
  logic result_stall = 1'b0;

  mean_reversion_half_life_unit u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .close_price(close_price), .price_valid(price_valid),
    .price_stall(price_stall), .half_life(half_life),
    .result_valid(result_valid), .result_stall(result_stall)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic [9:0] cur_window;
  logic [6:0] cur_horizon;
  logic [30:0] close_ring [WIN_DEPTH];
  logic [40:0] bar_sum [HOR_DEPTH];
  logic [10:0] bar_count [HOR_DEPTH];
  logic [41:0] bar_dev [HOR_DEPTH];
  logic [6:0] bar_found [HOR_DEPTH];
  int unsigned close_pos, bar_pos, bars_taken;
  logic [6:0] half_life_q[$];

  int errors = 0;
  int results_seen = 0;
  int sent = 0;
  bit stall_on = 1'b1;
  bit gaps_on = 1'b1;
  longint cycles = 0;

  function automatic logic [41:0] absdiff(logic [41:0] a, logic [41:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Advance the predictor by one close; queue the half life it releases
  task automatic predict_half_life(logic [30:0] c);
    int unsigned w, h, n, slot;
    logic [41:0] s, d, x;
    w = (cur_window > 10'd1023) ? 1023 : cur_window;
    h = (cur_horizon < 1) ? 1 : ((cur_horizon > 64) ? 64 : cur_horizon);
    close_ring[close_pos] = c;
    n = ((bars_taken < w) ? bars_taken : w) + 1;
    s = '0;
    for (int k = 0; k < n; k++)
      s += close_ring[(close_pos + WIN_DEPTH - k) % WIN_DEPTH];
    d = absdiff(42'(n) * c, s);
    for (int a = 1; a <= h; a++) begin
      if (bars_taken < a) break;
      slot = (bar_pos + HOR_DEPTH - a) % HOR_DEPTH;
      if (bar_found[slot] == 0 && bar_dev[slot] != 0) begin
        x = absdiff(42'(bar_count[slot]) * c, 42'(bar_sum[slot]));
        if ({x, 1'b0} <= {1'b0, bar_dev[slot]}) bar_found[slot] = 7'(a);
      end
    end
    if (bars_taken >= h)
      half_life_q.push_back(bar_found[(bar_pos + HOR_DEPTH - h) % HOR_DEPTH]);
    bar_sum[bar_pos] = s[40:0];
    bar_count[bar_pos] = 11'(n);
    bar_dev[bar_pos] = d;
    bar_found[bar_pos] = '0;
    close_pos = (close_pos + 1) % WIN_DEPTH;
    bar_pos = (bar_pos + 1) % HOR_DEPTH;
    if (bars_taken < 2047) bars_taken++;
  endtask

  // Send one close; hold it until the transfer happens, valid stays up after
  task automatic send_close(logic [30:0] c);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      price_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    price_valid <= 1'b1;
    close_price <= c;
    @(posedge clk);
    while (price_stall) @(posedge clk);
    predict_half_life(c);
    sent++;
  endtask

  // Write one register over APB (block must be idle), then leave the bus idle
  task automatic write_reg(logic idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_ADDR_BITS'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) cur_window = val[9:0];
    else cur_horizon = val[6:0];
    @(posedge clk);
  endtask

  // Drop valid, wait until every queued half life arrived, then let the block settle
  task automatic drain();
    price_valid <= 1'b0;
    while (half_life_q.size() != 0) @(posedge clk);
    repeat (7 + 2 * 1024 + 3 * 64 + 20) @(posedge clk);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (half_life_q.size() == 0) begin
        $display("%0t: unexpected half_life, expected none, actual %0d", $time, half_life);
        errors++;
      end else begin
        logic [6:0] want;
        want = half_life_q.pop_front();
        if (want !== half_life) begin
          $display("%0t: half_life mismatch, expected %0d, actual %0d",
                   $time, want, half_life);
          errors++;
        end
      end
    end
  end

  // Random receiver stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      result_stall <= 1'b0;
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [30:0] rand_close();
    logic [30:0] v;
    case ($urandom_range(0, 3))
      0: v = 31'($urandom());
      1: v = 31'd1000 + 31'($urandom_range(0, 20));
      2: v = 31'h7FFF_FFFF - 31'($urandom_range(0, 20));
      default: v = 31'($urandom_range(0, 20));
    endcase
    return v;
  endfunction

  // Extremes of the price, warm-up, zero deviation
  task automatic test_directed();
    send_close('0);
    send_close(31'h7FFF_FFFF);
    repeat (4) send_close(31'd500);
    send_close(31'h5555_5555);
    send_close(31'h2AAA_AAAA);
    for (int i = 0; i < 12; i++) send_close(31'd1000 + ((i % 2) ? 31'd40 : 31'd0));
    send_close(31'd0);
    send_close(31'h7FFF_FFFF);
    drain();
  endtask

  // Random closes scattered around a fixed base under one setting
  task automatic test_random_phase(logic [9:0] win, logic [6:0] hor, int count);
    logic [30:0] base;
    write_reg(REG_WINDOW_LENGTH, {22'($urandom()), win});
    write_reg(REG_HORIZON, {25'($urandom()), hor});
    base = 31'd100000;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) send_close(rand_close());
      else send_close(base + 31'($urandom_range(0, 200)) - 31'd100);
    end
    drain();
  endtask

  // Horizon and window changed between items while earlier bars are still pending
  task automatic test_midstream_change();
    for (int i = 0; i < 30; i++) send_close(31'd2000 + 31'($urandom_range(0, 50)));
    drain();
    write_reg(REG_HORIZON, 32'd3);
    write_reg(REG_WINDOW_LENGTH, 32'd1023);
    for (int i = 0; i < 40; i++) send_close(31'd2000 + 31'($urandom_range(0, 50)));
    drain();
  endtask

  initial begin
    cur_window = WINDOW_LENGTH_RESET;
    cur_horizon = HORIZON_RESET;
    close_pos = 0; bar_pos = 0; bars_taken = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(10'd0, 7'd1, 250);
    test_random_phase(10'd1023, 7'd64, 200);
    test_random_phase(10'd5, 7'd0, 200);
    test_random_phase(10'd200, 7'd127, 200);
    test_random_phase(10'($urandom_range(1, 60)), 7'($urandom_range(2, 20)), 300);
    test_midstream_change();
    gaps_on = 1'b0;
    stall_on = 1'b0;
    test_random_phase(10'd3, 7'd8, 300);
    $display("Sent %0d closes across window/horizon settings incl. extremes;", sent);
    $display("checked %0d half-life results.", results_seen);
    if (errors == 0 && half_life_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
